// ----- design/tmtc_pkg.sv -----
package tmtc_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    // field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int POS_W      = 31;
    localparam int RATE_W     = 16;
    localparam int SECS_W     = 48;
    localparam int VALUE_W    = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int REF_W      = 10;
    localparam int COUNT_W    = 7;

    // request tdata layout, lowest field first
    localparam int IDX_LSB    = 0;
    localparam int POS_LSB    = IDX_LSB + IDX_W;
    localparam int BPM_LSB    = POS_LSB + POS_W;
    localparam int START_LSB  = BPM_LSB + RATE_W;
    localparam int END_LSB    = START_LSB + POS_W;
    localparam int SECS_LSB   = END_LSB + POS_W;
    localparam int IN_USED_W  = SECS_LSB + SECS_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICKS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ADJ   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ABS_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REF_TEMPO   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd2;

    localparam logic [REF_W-1:0]   REF_TEMPO_RST   = 10'd120;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 7'd1;

    localparam logic signed [63:0] SUM_LIM = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;
    localparam logic [63:0]        MASK48  = 64'h0000_FFFF_FFFF_FFFF;

    function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > SUM_LIM)
            r = SUM_LIM;
        else if (v < -SUM_LIM)
            r = -SUM_LIM;
        return r;
    endfunction

    // both operands already inside +-2^61, so the 64-bit sum cannot wrap
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return clamp_lim(a + b);
    endfunction

    function automatic logic [VALUE_W-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > OUT_MAX)
            r = OUT_MAX;
        else if (v < OUT_MIN)
            r = OUT_MIN;
        return r[VALUE_W-1:0];
    endfunction

    function automatic logic signed [63:0] pos_diff(input logic [POS_W-1:0] a,
                                                    input logic [POS_W-1:0] b);
        return $signed({33'b0, a}) - $signed({33'b0, b});
    endfunction

endpackage

// ----- design/tempo_map_time_converter.sv -----
// Tempo map time converter: tick <-> seconds over a table of (position, BPM)
// entries.
// Request channel s_*: tuser carries the command (write entry, seconds
// between ticks, ticks after seconds, adjusted ticks), tdata the operands.
// Result channel m_*: tdata is the signed Q31.16 value, tuser the status
// flag (set only when the end segment precedes the start segment).
// Configuration writes (cfg_*) are registered; the user must issue them
// only while idle, the block does not enforce it. One request at a time:
// s_tready is high only while the sequencer idles. Queries scan the
// table once where a segment search is needed, then compute each segment
// term on the shared radix-2 divider (64 quotient bits, one per cycle).
// Reset clears the sequencer, the result register and the configuration
// (absolute mode off, reference tempo 120, one entry); the table is not
// cleared and holds garbage until written.
// A stalled result register holds its value; the next request may be
// accepted meanwhile, and its result waits until the register frees.
module tempo_map_time_converter #(
    parameter int MAX_ENTRIES = tmtc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // entry_index, entry_position, entry_bpm, start_ticks, end_ticks,
    // offset_secs, zero pad
    input  logic [tmtc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // command
    input  logic [tmtc_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // value
    output logic [tmtc_pkg::VALUE_W-1:0]         m_tdata,
    // status
    output logic                                 m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [tmtc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tmtc_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import tmtc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SCAN  = 5'd1;
    localparam logic [4:0] S_A0    = 5'd2;
    localparam logic [4:0] S_A1    = 5'd3;
    localparam logic [4:0] S_WRD   = 5'd4;
    localparam logic [4:0] S_WDEC  = 5'd5;
    localparam logic [4:0] S_WACC  = 5'd6;
    localparam logic [4:0] S_OCMP  = 5'd7;
    localparam logic [4:0] S_OACC  = 5'd8;
    localparam logic [4:0] S_I1    = 5'd9;
    localparam logic [4:0] S_I2    = 5'd10;
    localparam logic [4:0] S_WDONE = 5'd11;
    localparam logic [4:0] S_AADD  = 5'd12;
    localparam logic [4:0] S_DEND  = 5'd13;
    localparam logic [4:0] S_TPREP = 5'd14;
    localparam logic [4:0] S_TMUL  = 5'd15;
    localparam logic [4:0] S_TDIV  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    // walk kinds
    localparam logic [1:0] WM_RANGE = 2'd0;
    localparam logic [1:0] WM_ABS   = 2'd1;
    localparam logic [1:0] WM_OFF   = 2'd2;

    // numerator scale for a segment term
    localparam logic [1:0] KM_SEC = 2'd0;
    localparam logic [1:0] KM_ONE = 2'd1;
    localparam logic [1:0] KM_ABS = 2'd2;

    // configuration
    logic               abs_mode_reg;
    logic [REF_W-1:0]   ref_tempo_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    // sequencer
    logic [4:0]              state_reg, state_next, ret_reg, ret_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic                    phase_reg, phase_next;
    logic [1:0]              wmode_reg, wmode_next;
    logic                    final_reg, final_next;
    logic [POS_W-1:0]        start_reg, start_next, end_reg, end_next;
    logic [POS_W-1:0]        walk_t_reg, walk_t_next, cur_reg, cur_next;
    logic [POS_W-1:0]        pos_nx_reg, pos_nx_next;
    logic [SECS_W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]           n_reg, n_next, i_reg, i_next;
    logic [AW-1:0]           s_reg, s_next, e_reg, e_next, sidx_reg, sidx_next;
    logic                    scan_v_reg, scan_v_next;
    logic [RATE_W-1:0]       rate_cur_reg, rate_cur_next, r_reg, r_next;
    logic [RATE_W-1:0]       den_reg, den_next;
    logic signed [63:0]      acc_reg, acc_next, aux_reg, aux_next, len_reg, len_next;
    logic                    term_neg_reg, term_neg_next;
    logic [1:0]              kmode_reg, kmode_next;
    logic                    status_reg, status_next;

    // shared divider and multiplier
    logic [63:0]             divq_reg, divq_next;
    logic [RATE_W:0]         divr_reg, divr_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [63:0]             prod_reg;
    logic                    mul_en;
    logic [SECS_W-1:0]       mul_a;
    logic [RATE_W-1:0]       mul_b;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]      value_reg, value_next;
    logic                    out_status_reg, out_status_next;

    // tempo table
    logic [POS_W-1:0]        pos_mem  [MAX_ENTRIES];
    logic [RATE_W-1:0]       rate_mem [MAX_ENTRIES];
    logic [AW-1:0]           pos_raddr, rate_raddr, waddr;
    logic [POS_W-1:0]        rd_pos_reg;
    logic [RATE_W-1:0]       rd_rate_reg;
    logic                    wr_en;

    // helpers
    logic                    accept;
    logic [IDX_W-1:0]        in_idx;
    int                      n_int;
    logic [REF_W-1:0]        d_w;
    logic [63:0]             qsat;
    logic signed [63:0]      term_val;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = out_status_reg;

    assign in_idx = s_tdata[IDX_LSB +: IDX_W];
    assign wr_en  = accept && (s_tuser == CMD_WRITE) && (int'(in_idx) < MAX_ENTRIES);
    assign waddr  = AW'(int'(in_idx));
    assign d_w    = (ref_tempo_reg == '0) ? REF_W'(1) : ref_tempo_reg;

    // clamp the entry count into 1..MAX_ENTRIES
    always_comb
    begin
        if (entry_count_reg == '0)
            n_int = 1;
        else if (int'(entry_count_reg) > MAX_ENTRIES)
            n_int = MAX_ENTRIES;
        else
            n_int = int'(entry_count_reg);
    end

    // divider quotient, saturated and signed as a segment term
    assign qsat     = (divq_reg > 64'(SUM_LIM)) ? 64'(SUM_LIM) : divq_reg;
    assign term_val = term_neg_reg ? -$signed(qsat) : $signed(qsat);

    always_comb
    begin
        logic [CW-1:0]        ip1;
        logic [RATE_W-1:0]    rate_w;
        logic signed [63:0]   lenw;
        logic [63:0]          mag;
        logic [RATE_W:0]      rtry;
        logic [19:0]          lo;
        logic [63:0]          interp;
        logic [63:0]          rsum;

        ip1    = i_reg + CW'(1);
        rate_w = (rd_rate_reg == '0) ? RATE_W'(1) : rd_rate_reg;
        lenw   = '0;
        mag    = len_reg[63] ? 64'(-len_reg) : 64'(len_reg);
        rtry   = {divr_reg[RATE_W-1:0], divq_reg[63]};
        lo     = (20'(rem_reg[2:0]) * 20'(r_reg)) + 20'd4;
        interp = prod_reg + 64'(lo[19:3]);
        rsum   = {16'b0, rem_reg} + qsat;

        state_next      = state_reg;
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        phase_next      = phase_reg;
        wmode_next      = wmode_reg;
        final_next      = final_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        walk_t_next     = walk_t_reg;
        cur_next        = cur_reg;
        pos_nx_next     = pos_nx_reg;
        rem_next        = rem_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        sidx_next       = sidx_reg;
        scan_v_next     = scan_v_reg;
        rate_cur_next   = rate_cur_reg;
        r_next          = r_reg;
        den_next        = den_reg;
        acc_next        = acc_reg;
        aux_next        = aux_reg;
        len_next        = len_reg;
        term_neg_next   = term_neg_reg;
        kmode_next      = kmode_reg;
        status_next     = status_reg;
        divq_next       = divq_reg;
        divr_next       = divr_reg;
        cnt_next        = cnt_reg;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        pos_raddr       = i_reg[AW-1:0];
        rate_raddr      = i_reg[AW-1:0];
        out_valid_next  = out_valid_reg && !m_tready;
        value_next      = value_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    start_next  = s_tdata[START_LSB +: POS_W];
                    end_next    = s_tdata[END_LSB +: POS_W];
                    rem_next    = s_tdata[SECS_LSB +: SECS_W];
                    n_next      = CW'(n_int);
                    i_next      = '0;
                    s_next      = '0;
                    e_next      = '0;
                    scan_v_next = 1'b0;
                    phase_next  = 1'b0;
                    acc_next    = '0;
                    status_next = 1'b0;
                    case (s_tuser)
                        CMD_WRITE:
                            state_next = S_FIN;
                        CMD_SECS:
                        begin
                            walk_t_next = s_tdata[END_LSB +: POS_W];
                            state_next  = abs_mode_reg ? S_A0 : S_SCAN;
                        end
                        CMD_TICKS:
                        begin
                            walk_t_next = s_tdata[START_LSB +: POS_W];
                            state_next  = abs_mode_reg ? S_A0 : S_SCAN;
                        end
                        default:
                        begin
                            walk_t_next = s_tdata[START_LSB +: POS_W];
                            acc_next    = $signed(64'(s_tdata[START_LSB +: POS_W]) << 16);
                            state_next  = abs_mode_reg ? S_A0 : S_FIN;
                        end
                    endcase
                end
            end

            // find the last entry at or below start and end, one per cycle
            S_SCAN:
            begin
                if (scan_v_reg)
                begin
                    if (rd_pos_reg <= start_reg)
                        s_next = sidx_reg;
                    if (rd_pos_reg <= end_reg)
                        e_next = sidx_reg;
                end
                if (i_reg < n_reg)
                begin
                    pos_raddr   = i_reg[AW-1:0];
                    scan_v_next = 1'b1;
                    sidx_next   = i_reg[AW-1:0];
                    i_next      = ip1;
                end
                else
                begin
                    scan_v_next = 1'b0;
                    if (!scan_v_reg)
                    begin
                        i_next   = CW'(s_reg);
                        cur_next = start_reg;
                        acc_next = '0;
                        if (cmd_reg == CMD_SECS)
                        begin
                            wmode_next = WM_RANGE;
                            if (e_reg < s_reg)
                            begin
                                status_next = 1'b1;
                                state_next  = S_FIN;
                            end
                            else
                                state_next = S_WRD;
                        end
                        else
                        begin
                            wmode_next = WM_OFF;
                            state_next = S_WRD;
                        end
                    end
                end
            end

            S_A0:
            begin
                pos_raddr  = '0;
                state_next = S_A1;
            end

            S_A1:
            begin
                cur_next   = rd_pos_reg;
                i_next     = '0;
                acc_next   = '0;
                wmode_next = WM_ABS;
                state_next = S_WRD;
            end

            // fetch the next entry position and this segment's rate
            S_WRD:
            begin
                pos_raddr  = ip1[AW-1:0];
                rate_raddr = i_reg[AW-1:0];
                state_next = S_WDEC;
            end

            S_WDEC:
            begin
                pos_nx_next   = rd_pos_reg;
                rate_cur_next = rate_w;
                den_next      = rate_w;
                kmode_next    = KM_SEC;
                ret_next      = S_WACC;
                case (wmode_reg)
                    WM_RANGE:
                    begin
                        if (i_reg < CW'(e_reg))
                        begin
                            len_next   = pos_diff(rd_pos_reg, cur_reg);
                            final_next = 1'b0;
                        end
                        else
                        begin
                            len_next   = pos_diff(end_reg, cur_reg);
                            final_next = 1'b1;
                        end
                        state_next = S_TPREP;
                    end
                    WM_ABS:
                    begin
                        kmode_next = KM_ABS;
                        if (ip1 < n_reg && rd_pos_reg < walk_t_reg)
                        begin
                            len_next   = pos_diff(rd_pos_reg, cur_reg);
                            final_next = 1'b0;
                        end
                        else
                        begin
                            len_next   = pos_diff(walk_t_reg, cur_reg);
                            final_next = 1'b1;
                        end
                        state_next = S_TPREP;
                    end
                    default:
                    begin
                        if (ip1 < n_reg)
                        begin
                            lenw     = pos_diff(rd_pos_reg, cur_reg);
                            len_next = lenw;
                            ret_next = S_OACC;
                            if (lenw[63])
                                state_next = S_TPREP;
                            else
                            begin
                                mul_en     = 1'b1;
                                mul_a      = rem_reg;
                                mul_b      = rate_w;
                                state_next = S_OCMP;
                            end
                        end
                        else
                        begin
                            r_next     = rate_w;
                            state_next = S_I1;
                        end
                    end
                endcase
            end

            S_WACC:
            begin
                acc_next = sat_add(acc_reg, term_val);
                if (final_reg)
                    state_next = S_WDONE;
                else
                begin
                    cur_next   = pos_nx_reg;
                    i_next     = ip1;
                    state_next = S_WRD;
                end
            end

            // pass the segment only when the offset outlasts it
            S_OCMP:
            begin
                if ((64'(len_reg) << 19) < prod_reg)
                    state_next = S_TPREP;
                else
                begin
                    r_next     = rate_cur_reg;
                    state_next = S_I1;
                end
            end

            S_OACC:
            begin
                if (term_neg_reg)
                    rem_next = (rsum > MASK48) ? MASK48[SECS_W-1:0] : rsum[SECS_W-1:0];
                else
                    rem_next = rem_reg - qsat[SECS_W-1:0];
                cur_next   = pos_nx_reg;
                i_next     = ip1;
                state_next = S_WRD;
            end

            S_I1:
            begin
                mul_en     = 1'b1;
                mul_a      = {3'b0, rem_reg[SECS_W-1:3]};
                mul_b      = r_reg;
                state_next = S_I2;
            end

            S_I2:
            begin
                if (interp > 64'(SUM_LIM))
                    interp = 64'(SUM_LIM);
                acc_next   = sat_add($signed(64'(cur_reg) << 16), $signed(interp));
                state_next = S_FIN;
            end

            S_WDONE:
            begin
                if (cmd_reg == CMD_TICKS)
                begin
                    mul_en     = 1'b1;
                    mul_a      = rem_reg;
                    mul_b      = RATE_W'({d_w, 3'b0});
                    state_next = S_AADD;
                end
                else if (cmd_reg == CMD_SECS && abs_mode_reg)
                begin
                    if (!phase_reg)
                    begin
                        aux_next    = acc_reg;
                        phase_next  = 1'b1;
                        walk_t_next = start_reg;
                        state_next  = S_A0;
                    end
                    else
                    begin
                        len_next   = clamp_lim(aux_reg - acc_reg);
                        kmode_next = KM_ONE;
                        den_next   = RATE_W'({d_w, 3'b0});
                        ret_next   = S_DEND;
                        state_next = S_TPREP;
                    end
                end
                else
                    state_next = S_FIN;
            end

            S_AADD:
            begin
                acc_next   = sat_add(acc_reg, clamp_lim($signed(prod_reg)));
                state_next = S_FIN;
            end

            S_DEND:
            begin
                acc_next   = term_val;
                state_next = S_FIN;
            end

            // segment term: |len| * K + den/2, then divide by den
            S_TPREP:
            begin
                term_neg_next = len_reg[63];
                divr_next     = '0;
                cnt_next      = '0;
                case (kmode_reg)
                    KM_SEC:
                    begin
                        divq_next  = (mag << 19) + 64'(den_reg >> 1);
                        state_next = S_TDIV;
                    end
                    KM_ONE:
                    begin
                        divq_next  = mag + 64'(den_reg >> 1);
                        state_next = S_TDIV;
                    end
                    default:
                    begin
                        mul_en     = 1'b1;
                        mul_a      = mag[SECS_W-1:0];
                        mul_b      = RATE_W'(d_w);
                        state_next = S_TMUL;
                    end
                endcase
            end

            S_TMUL:
            begin
                divq_next  = (prod_reg << 22) + 64'(den_reg >> 1);
                state_next = S_TDIV;
            end

            // restoring division, one quotient bit per cycle
            S_TDIV:
            begin
                if (rtry >= {1'b0, den_reg})
                begin
                    divr_next = rtry - {1'b0, den_reg};
                    divq_next = {divq_reg[62:0], 1'b1};
                end
                else
                begin
                    divr_next = rtry;
                    divq_next = {divq_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ret_reg;
            end

            // hold until the result register frees
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    value_next      = sat48(acc_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_mode_reg    <= 1'b0;
            ref_tempo_reg   <= REF_TEMPO_RST;
            entry_count_reg <= ENTRY_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_ABS_MODE:    abs_mode_reg    <= cfg_wr_data[0];
                REG_REF_TEMPO:   ref_tempo_reg   <= cfg_wr_data[REF_W-1:0];
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wr_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // tempo table, registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[waddr]  <= s_tdata[POS_LSB +: POS_W];
            rate_mem[waddr] <= s_tdata[BPM_LSB +: RATE_W];
        end
        rd_pos_reg  <= pos_mem[pos_raddr];
        rd_rate_reg <= rate_mem[rate_raddr];
    end

    // shared multiplier
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            cmd_reg        <= CMD_WRITE;
            phase_reg      <= 1'b0;
            wmode_reg      <= WM_RANGE;
            final_reg      <= 1'b0;
            start_reg      <= '0;
            end_reg        <= '0;
            walk_t_reg     <= '0;
            cur_reg        <= '0;
            pos_nx_reg     <= '0;
            rem_reg        <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            s_reg          <= '0;
            e_reg          <= '0;
            sidx_reg       <= '0;
            scan_v_reg     <= 1'b0;
            rate_cur_reg   <= '0;
            r_reg          <= '0;
            den_reg        <= '0;
            acc_reg        <= '0;
            aux_reg        <= '0;
            len_reg        <= '0;
            term_neg_reg   <= 1'b0;
            kmode_reg      <= KM_SEC;
            status_reg     <= 1'b0;
            divq_reg       <= '0;
            divr_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cmd_reg        <= cmd_next;
            phase_reg      <= phase_next;
            wmode_reg      <= wmode_next;
            final_reg      <= final_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            walk_t_reg     <= walk_t_next;
            cur_reg        <= cur_next;
            pos_nx_reg     <= pos_nx_next;
            rem_reg        <= rem_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            s_reg          <= s_next;
            e_reg          <= e_next;
            sidx_reg       <= sidx_next;
            scan_v_reg     <= scan_v_next;
            rate_cur_reg   <= rate_cur_next;
            r_reg          <= r_next;
            den_reg        <= den_next;
            acc_reg        <= acc_next;
            aux_reg        <= aux_next;
            len_reg        <= len_next;
            term_neg_reg   <= term_neg_next;
            kmode_reg      <= kmode_next;
            status_reg     <= status_next;
            divq_reg       <= divq_next;
            divr_reg       <= divr_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            value_reg      <= value_next;
            out_status_reg <= out_status_next;
        end
    end

`ifndef SYNTH
    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TDIV |-> den_reg != '0)
        else $error("divider started with zero divisor");

    a_write_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_WRITE |=> state_reg == S_FIN)
        else $error("write request did not go straight to result");

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRD |-> i_reg < n_reg)
        else $error("segment walk ran past the table");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error status with nonzero value");
`endif

endmodule

// ----- tb/sv/tempo_map_time_converter_tb.sv -----
module tempo_map_time_converter_tb;

    import tmtc_pkg::*;

    localparam int    TABLE_DEPTH  = 64;
    localparam int    STALL_LIMIT  = 60000;
    localparam int    DRAIN_CYCLES = 300;
    localparam longint SAT_LIM     = 64'sh2000_0000_0000_0000;
    localparam longint VAL_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VAL_MIN     = -64'sh0000_8000_0000_0000;
    localparam longint unsigned SECS_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint unsigned SEC_SCALE = 64'h8_0000;
    localparam logic [POS_W-1:0] POS_MAX  = '1;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               status;
    } conv_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [VALUE_W-1:0]     m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    // shadow of the tempo table and configuration
    logic [POS_W-1:0]       tick_pos [TABLE_DEPTH];
    logic [RATE_W-1:0]      tick_rate[TABLE_DEPTH];
    logic                   abs_mode;
    logic [REF_W-1:0]       ref_bpm;
    logic [COUNT_W-1:0]     active_entries;

    conv_result_t           pending_results[$];
    int                     error_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     hold_left;
    int                     stall_cycles;

    tempo_map_time_converter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Conversion arithmetic
    // ---------------------------------------------------------------

    function automatic longint clip61(input longint v);
        if (v > SAT_LIM)
            return SAT_LIM;
        if (v < -SAT_LIM)
            return -SAT_LIM;
        return v;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        return clip61(clip61(a) + clip61(b));
    endfunction

    function automatic longint pos_at(input int i);
        return longint'({33'b0, tick_pos[i]});
    endfunction

    // zero rate divides as one
    function automatic longint unsigned rate_at(input int i);
        return (tick_rate[i] == 0) ? 64'd1 : longint'({48'b0, tick_rate[i]});
    endfunction

    // |len|*k/r rounded half up, sign of len, capped at the sum limit
    function automatic longint scaled_term(input longint len, input longint unsigned k,
                                           input longint unsigned r);
        longint unsigned m;
        longint unsigned q;
        m = (len < 0) ? longint'(-len) : len;
        q = (m * k + r / 2) / r;
        if (q > longint'(SAT_LIM))
            q = SAT_LIM;
        return (len < 0) ? -longint'(q) : longint'(q);
    endfunction

    // last entry below n whose position is at or below the tick, else entry 0
    function automatic int seg_lookup(input int n, input longint t);
        int found;
        found = 0;
        for (int i = 0; i < n; i++)
            if (pos_at(i) <= t)
                found = i;
        return found;
    endfunction

    // tick count rescaled segment by segment up to tick t
    function automatic longint tick_integral(input int n, input longint t,
                                             input longint unsigned k);
        longint acc;
        int     i;
        acc = 0;
        i = 0;
        while (i + 1 < n && pos_at(i + 1) < t)
        begin
            acc = add_sat(acc, scaled_term(pos_at(i + 1) - pos_at(i), k, rate_at(i)));
            i++;
        end
        return add_sat(acc, scaled_term(t - pos_at(i), k, rate_at(i)));
    endfunction

    function automatic longint ticks_after_offset(input int n, input longint start,
                                                  input longint unsigned secs);
        longint          cur;
        longint          len;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned ri;
        longint unsigned interp;
        cur = start;
        rem = secs;
        r = rate_at(n - 1);
        for (int i = seg_lookup(n, start); i + 1 < n; i++)
        begin
            ri = rate_at(i);
            len = pos_at(i + 1) - cur;
            if (len < 0)
            begin
                // a backward segment gives its duration back to the offset
                rem = rem + longint'(-scaled_term(len, SEC_SCALE, ri));
                if (rem > SECS_MASK)
                    rem = SECS_MASK;
            end
            else if ((longint'(len) << 19) < rem * ri)
                rem = rem - longint'(scaled_term(len, SEC_SCALE, ri));
            else
            begin
                r = ri;
                break;
            end
            cur = pos_at(i + 1);
        end
        interp = (rem >> 3) * r + (((rem & 64'd7) * r + 64'd4) >> 3);
        if (interp > longint'(SAT_LIM))
            interp = SAT_LIM;
        return add_sat(cur << 16, longint'(interp));
    endfunction

    // advance the shadow state by one request and return its result
    function automatic conv_result_t convert_request(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [RATE_W-1:0] bpm,
                                                     input logic [POS_W-1:0] start_t,
                                                     input logic [POS_W-1:0] stop_t,
                                                     input logic [SECS_W-1:0] secs);
        conv_result_t    res;
        int              n;
        int              s;
        int              e;
        longint          start;
        longint          stop;
        longint          v;
        longint          diff;
        longint unsigned d;
        longint unsigned kabs;
        n = (active_entries == 0) ? 1 : int'(active_entries);
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        start = longint'({33'b0, start_t});
        stop = longint'({33'b0, stop_t});
        d = (ref_bpm == 0) ? 64'd1 : longint'({54'b0, ref_bpm});
        kabs = d << 22;
        v = 0;
        res.status = 1'b0;
        case (cmd)
            CMD_WRITE:
            begin
                tick_pos[idx] = pos;
                tick_rate[idx] = bpm;
            end
            CMD_SECS:
            begin
                if (abs_mode)
                begin
                    diff = add_sat(tick_integral(n, stop, kabs), -tick_integral(n, start, kabs));
                    v = scaled_term(diff, 64'd1, 8 * d);
                end
                else
                begin
                    s = seg_lookup(n, start);
                    e = seg_lookup(n, stop);
                    if (s == e)
                        v = scaled_term(stop - start, SEC_SCALE, rate_at(s));
                    else if (e < s)
                        res.status = 1'b1;
                    else
                    begin
                        v = scaled_term(pos_at(s + 1) - start, SEC_SCALE, rate_at(s));
                        for (int i = s + 1; i < e; i++)
                            v = add_sat(v, scaled_term(pos_at(i + 1) - pos_at(i),
                                                       SEC_SCALE, rate_at(i)));
                        v = add_sat(v, scaled_term(stop - pos_at(e), SEC_SCALE, rate_at(e)));
                    end
                end
            end
            CMD_TICKS:
            begin
                if (abs_mode)
                    v = add_sat(tick_integral(n, start, kabs),
                                clip61(longint'(d * 8 * {16'b0, secs})));
                else
                    v = ticks_after_offset(n, start, {16'b0, secs});
            end
            default:
            begin
                if (abs_mode)
                    v = tick_integral(n, start, kabs);
                else
                    v = start << 16;
            end
        endcase
        if (v > VAL_MAX)
            v = VAL_MAX;
        else if (v < VAL_MIN)
            v = VAL_MIN;
        res.value = v[VALUE_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [POS_W-1:0] pos, input logic [RATE_W-1:0] bpm,
                                input logic [POS_W-1:0] start_t, input logic [POS_W-1:0] stop_t,
                                input logic [SECS_W-1:0] secs);
        logic [IN_TDATA_W-1:0] packed_req;
        conv_result_t          res;
        packed_req = '0;
        packed_req[IDX_LSB +: IDX_W] = idx;
        packed_req[POS_LSB +: POS_W] = pos;
        packed_req[BPM_LSB +: RATE_W] = bpm;
        packed_req[START_LSB +: POS_W] = start_t;
        packed_req[END_LSB +: POS_W] = stop_t;
        packed_req[SECS_LSB +: SECS_W] = secs;
        // idle the request side for a random gap
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= packed_req;
        s_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        res = convert_request(cmd, idx, pos, bpm, start_t, stop_t, secs);
        pending_results.push_back(res);
    endtask

    task automatic send_query(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] start_t,
                              input logic [POS_W-1:0] stop_t, input logic [SECS_W-1:0] secs);
        send_request(cmd, IDX_W'($urandom), POS_W'($urandom), RATE_W'($urandom),
                     start_t, stop_t, secs);
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                               input logic [RATE_W-1:0] bpm);
        send_request(CMD_WRITE, idx, pos, bpm, POS_W'($urandom), POS_W'($urandom),
                     SECS_W'({$urandom, $urandom}));
    endtask

    // drop valid and hold until every result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        case (addr)
            REG_ABS_MODE:    abs_mode = data[0];
            REG_REF_TEMPO:   ref_bpm = data[REF_W-1:0];
            REG_ENTRY_COUNT: active_entries = data[COUNT_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(input logic mode, input int ref_val, input int count);
        drain_results();
        write_reg(REG_ABS_MODE, CFG_DATA_W'(mode));
        write_reg(REG_REF_TEMPO, CFG_DATA_W'(ref_val));
        write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(count));
    endtask

    function automatic logic [SECS_W-1:0] random_offset();
        int                  w;
        logic [63:0]         raw;
        w = $urandom_range(1, SECS_W);
        raw = {$urandom, $urandom};
        return SECS_W'(raw & ((64'd1 << w) - 1));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // extremes, every command and the named corner cases on a small table
    task automatic test_directed();
        write_entry(0, 0, 16'hFFFF);
        send_query(CMD_ADJ, POS_MAX, 0, 0);
        send_query(CMD_SECS, 0, POS_MAX, 0);
        send_query(CMD_TICKS, POS_MAX, 0, '1);
        write_entry(1, 1000, 16'd1);
        write_entry(2, 2000, 16'd0);          // zero rate
        write_entry(3, POS_MAX, 16'd7680);
        apply_config(1'b0, 120, 4);
        send_query(CMD_SECS, 100, 2500, 0);  // spans segments
        send_query(CMD_SECS, 2500, 500, 0);  // end before start across segments
        send_query(CMD_SECS, 900, 100, 0);   // negative within one segment
        send_query(CMD_TICKS, 500, 0, 48'd40000);
        send_query(CMD_TICKS, POS_MAX, 0, '1);
        send_query(CMD_TICKS, 0, 0, 48'd1 << 40);
        send_query(CMD_ADJ, 2500, 0, 0);
        apply_config(1'b1, 1023, 4);
        send_query(CMD_SECS, 0, POS_MAX, 0);
        send_query(CMD_TICKS, 1500, 0, '1);
        send_query(CMD_ADJ, POS_MAX, 0, 0);
        apply_config(1'b1, 0, 0);             // zero tempo and zero count
        send_query(CMD_SECS, POS_MAX, 0, 0);
        send_query(CMD_ADJ, 1500, 0, 0);
        apply_config(1'b1, 1, 4);
        send_query(CMD_TICKS, 0, 0, 48'd12345);
    endtask

    // fill every slot so any entry count reads written entries only
    task automatic test_table_fill();
        apply_config(1'b0, 120, 1);
        for (int i = 0; i < TABLE_DEPTH; i++)
            write_entry(IDX_W'(i), POS_W'(i * 3000), RATE_W'($urandom_range(64, 16'hFFFF)));
    endtask

    // fresh table and configuration, then a stream of mostly queries
    task automatic test_random_mix(input int n_items, input int count);
        int               n;
        int               sorted;
        int               sel;
        longint           span;
        longint           p;
        logic [POS_W-1:0] t0;
        logic [POS_W-1:0] t1;
        int               ref_val;
        sel = $urandom_range(3);
        ref_val = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 1023 : $urandom_range(1, 1023);
        apply_config(1'($urandom), ref_val, count);
        n = (count == 0) ? 1 : (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        sorted = ($urandom_range(3) != 0);
        p = 0;
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
            begin
                if (i > 0)
                    p = p + (($urandom_range(7) == 0) ? $urandom_range(0, 1 << 24)
                                                       : $urandom_range(0, 5000));
                if (p > longint'({33'b0, POS_MAX}))
                    p = {33'b0, POS_MAX};
                write_entry(IDX_W'(i), POS_W'(p),
                            ($urandom_range(15) == 0) ? RATE_W'(0) : RATE_W'($urandom));
            end
            else
                write_entry(IDX_W'(i), POS_W'($urandom), RATE_W'($urandom));
        end
        span = p + 2000;
        if (span > longint'({33'b0, POS_MAX}))
            span = {33'b0, POS_MAX};
        for (int k = 0; k < n_items; k++)
        begin
            t0 = (sorted && $urandom_range(3) != 0) ? POS_W'($urandom_range(0, span))
                                                     : POS_W'($urandom);
            t1 = (sorted && $urandom_range(3) != 0) ? POS_W'($urandom_range(0, span))
                                                     : POS_W'($urandom);
            case ($urandom_range(9))
                0:       write_entry(IDX_W'($urandom), POS_W'(sorted ? $urandom_range(0, span)
                                                                     : $urandom),
                                     RATE_W'($urandom));
                1, 2, 3: send_query(CMD_SECS, t0, t1, SECS_W'({$urandom, $urandom}));
                4, 5, 6: send_query(CMD_TICKS, t0, t1, random_offset());
                default: send_query(CMD_ADJ, t0, t1, SECS_W'({$urandom, $urandom}));
            endcase
        end
    endtask

    // hold off the result side long enough for the request side to stall
    task automatic test_backpressure();
        apply_config(1'b0, 120, 1);
        hold_left = 400;
        for (int k = 0; k < 8; k++)
            send_query(CMD_ADJ, POS_W'($urandom), 0, 0);
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        conv_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result value %h status %b", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.value)
                begin
                    $error("value: expected %h actual %h", exp_res.value, m_tdata);
                    error_count++;
                end
                if (m_tuser !== exp_res.status)
                begin
                    $error("status: expected %b actual %b", exp_res.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_ABS_MODE;
        cfg_wr_data = '0;
        error_count = 0;
        hold_left = 0;
        stall_cycles = 0;
        abs_mode = 1'b0;
        ref_bpm = REF_TEMPO_RST;
        active_entries = ENTRY_COUNT_RST;
        send_idle_pct = 11;
        recv_idle_pct = 88;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_fill();
        test_backpressure();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 11 : 0;
            for (int k = 0; k < 6; k++)
                test_random_mix(75, $urandom_range(1, 5));
            // full and out-of-range counts walk long tables: keep them short
            test_random_mix(12, TABLE_DEPTH);
            test_random_mix(8, (phase == 1) ? 0 : 127);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
